@@ rtl/core/gac_pkg.sv @@
// Shared types and constants for the gamepad axis conditioner.
// Used by the front, queue, back and top-level files; no dependencies.
package gac_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam logic [5:0] HOLDOFF_MS = 6'd40;
   localparam logic [14:0] TRIG_SNAP = 15'd1000;
   localparam logic signed [16:0] STICK_FULL = 17'sd32767;
   localparam logic [16:0] DIV_DEN = 17'd32767;

   localparam logic [2:0] CSR_CLUTCH_ENABLE = 3'd0;
   localparam logic [2:0] CSR_BINDING_MODE  = 3'd1;
   localparam logic [2:0] CSR_KNOB_OVERRIDE = 3'd2;
   localparam logic [2:0] CSR_INVERT_ASSIST = 3'd3;
   localparam logic [2:0] CSR_AXIS_LOW      = 3'd4;
   localparam logic [2:0] CSR_AXIS_HIGH     = 3'd5;
   localparam logic [2:0] CSR_DEAD_BAND     = 3'd6;

   typedef struct packed {
      logic        clutch_enable;
      logic        binding_mode;
      logic        knob_override_enable;
      logic        invert_assist;
      logic [15:0] axis_low;
      logic [15:0] axis_high;
      logic [14:0] dead_band;
   } cfg_type;

   typedef enum logic [1:0] {
      Z_NONE  = 2'd0,
      Z_SNAP  = 2'd1,
      Z_SCALE = 2'd2
   } z_kind_type;

   typedef enum logic [1:0] {
      STK_NONE   = 2'd0,
      STK_CENTRE = 2'd1,
      STK_SCALE  = 2'd2
   } stk_kind_type;

   typedef struct packed {
      z_kind_type   z_kind;
      logic [14:0]  trig;
      stk_kind_type stk_kind;
      logic [15:0]  ux;
      logic [15:0]  uy;
   } job_type;

   typedef struct packed {
      logic [15:0] q;
      logic        rnz;
   } quot_type;

endpackage

@@ rtl/core/gac_front.sv @@
// Front end: accepts poll beats, runs the assist and hold-off logic and
// classifies each poll into a job for the back end. Depends on gac_pkg.
module gac_front (
   input  logic             clock,
   input  logic             reset,
   input  gac_pkg::cfg_type cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,
   input  logic             queue_full,
   output logic             push,
   output gac_pkg::job_type job
);

   logic        assist_was_held_ff, assist_was_held_in;
   logic [5:0]  holdoff_left_ff, holdoff_left_in;
   logic [5:0]  hold_dec;
   logic [14:0] trig;
   logic        pressed;
   logic [15:0] sx;
   logic [15:0] sy;
   logic [7:0]  elapsed;

   function automatic logic [15:0] stick_offset(input logic [15:0] raw,
                                                input logic [14:0] db,
                                                input logic snap);
      logic signed [16:0] s;
      logic signed [16:0] dbs;
      logic signed [16:0] v;
      logic signed [16:0] sum;
      s = $signed({raw[15], raw});
      if (raw == 16'h8000) begin
         s = -gac_pkg::STICK_FULL;
      end
      dbs = $signed({2'b00, db});
      if (s > dbs || s < -dbs) begin
         if (snap) begin
            v = (s > 17'sd0) ? gac_pkg::STICK_FULL : -gac_pkg::STICK_FULL;
         end else begin
            v = s;
         end
      end else begin
         v = 17'sd0;
      end
      sum = v + gac_pkg::STICK_FULL;
      return sum[15:0];
   endfunction

   assign trig    = req_tdata[14:0];
   assign pressed = req_tdata[15];
   assign sx      = req_tdata[31:16];
   assign sy      = req_tdata[47:32];
   assign elapsed = req_tdata[55:48];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   assign hold_dec = ({2'b00, holdoff_left_ff} > elapsed) ?
                     (holdoff_left_ff - elapsed[5:0]) : 6'd0;

   always_comb begin
      assist_was_held_in = assist_was_held_ff;
      holdoff_left_in    = hold_dec;
      job.stk_kind       = gac_pkg::STK_NONE;
      if (cfg.knob_override_enable) begin
         if (cfg.invert_assist) begin
            job.stk_kind = pressed ? gac_pkg::STK_SCALE : gac_pkg::STK_CENTRE;
         end else if (pressed) begin
            job.stk_kind       = gac_pkg::STK_CENTRE;
            assist_was_held_in = 1'b1;
         end else if (assist_was_held_ff) begin
            holdoff_left_in    = gac_pkg::HOLDOFF_MS;
            assist_was_held_in = 1'b0;
         end else if (hold_dec == 6'd0) begin
            job.stk_kind = gac_pkg::STK_SCALE;
         end
      end
      if (!cfg.clutch_enable) begin
         job.z_kind = gac_pkg::Z_NONE;
      end else if (cfg.binding_mode && trig > gac_pkg::TRIG_SNAP) begin
         job.z_kind = gac_pkg::Z_SNAP;
      end else begin
         job.z_kind = gac_pkg::Z_SCALE;
      end
      job.trig = trig;
      job.ux   = stick_offset(sx, cfg.dead_band, cfg.binding_mode);
      job.uy   = stick_offset(sy, cfg.dead_band, cfg.binding_mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         assist_was_held_ff <= 1'b0;
         holdoff_left_ff    <= 6'd0;
      end else if (push) begin
         assist_was_held_ff <= assist_was_held_in;
         holdoff_left_ff    <= holdoff_left_in;
      end
   end

endmodule

@@ rtl/core/gac_queue.sv @@
// Short job queue between front and back ends.
// Depends on gac_pkg for the job type and depth.
module gac_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gac_pkg::job_type push_job,
   input  logic             pop,
   output gac_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   localparam int PtrW = (gac_pkg::QUEUE_DEPTH > 1) ? $clog2(gac_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(gac_pkg::QUEUE_DEPTH + 1);

   gac_pkg::job_type     slot_ff [gac_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] n;
      if (p == PtrW'(gac_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PtrW'(1);
      end
      return n;
   endfunction

   assign empty    = (count_ff == CntW'(0));
   assign full     = (count_ff == CntW'(gac_pkg::QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/gac_back.sv @@
// Back end: multiply, divide-by-constant and offset pipeline that turns
// jobs into result beats, ending in the output register. Depends on gac_pkg.
module gac_back (
   input  logic             clock,
   input  logic             reset,
   input  gac_pkg::cfg_type cfg,
   input  gac_pkg::job_type head_job,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata
);

   typedef struct packed {
      gac_pkg::z_kind_type   z_kind;
      gac_pkg::stk_kind_type stk_kind;
      logic [30:0]           pz;
      logic [31:0]           px;
      logic [31:0]           py;
   } prod_type;

   typedef struct packed {
      gac_pkg::z_kind_type   z_kind;
      gac_pkg::stk_kind_type stk_kind;
      logic [30:0]           xz;
      logic [30:0]           xx;
      logic [30:0]           xy;
      logic                  px0;
      logic                  py0;
      logic [16:0]           qz;
      logic [16:0]           qx;
      logic [16:0]           qy;
   } est_type;

   typedef struct packed {
      gac_pkg::z_kind_type   z_kind;
      gac_pkg::stk_kind_type stk_kind;
      gac_pkg::quot_type     dz;
      gac_pkg::quot_type     dx;
      gac_pkg::quot_type     dy;
   } fix_type;

   logic        en;
   logic        neg;
   logic [15:0] dmag;
   logic [16:0] centre_sum;
   logic [15:0] centre;
   logic        s1_vld_ff, s2_vld_ff, s3_vld_ff, out_vld_ff;
   prod_type    s1_ff, s1_in;
   est_type     s2_ff, s2_in;
   fix_type     s3_ff, s3_in;
   logic [49:0] out_ff, out_in;
   gac_pkg::quot_type fx_dx;
   gac_pkg::quot_type fx_dy;

   function automatic logic [16:0] div_est(input logic [30:0] x);
      logic [31:0] sum;
      sum = {1'b0, x} + {16'b0, x[30:15]};
      return sum[31:15];
   endfunction

   function automatic gac_pkg::quot_type div_fix(input logic [30:0] x,
                                                 input logic [16:0] q0);
      logic [31:0]       r;
      logic [16:0]       q;
      gac_pkg::quot_type res;
      r = {1'b0, x} - {q0, 15'b0} + {15'b0, q0};
      q = q0 + ((r[16:0] >= gac_pkg::DIV_DEN) ? 17'd1 : 17'd0);
      res.q   = q[15:0];
      res.rnz = (r[16:0] != 17'd0) && (r[16:0] != gac_pkg::DIV_DEN);
      return res;
   endfunction

   function automatic logic [15:0] offset(input logic [15:0] lo,
                                          input gac_pkg::quot_type d,
                                          input logic down);
      logic [15:0] v;
      if (down) begin
         v = lo - d.q - {15'b0, d.rnz};
      end else begin
         v = lo + d.q;
      end
      return v;
   endfunction

   assign en  = !out_vld_ff || rsp_tready;
   assign pop = en && !queue_empty;

   assign neg        = cfg.axis_high < cfg.axis_low;
   assign dmag       = neg ? (cfg.axis_low - cfg.axis_high) : (cfg.axis_high - cfg.axis_low);
   assign centre_sum = {1'b0, cfg.axis_low} + {1'b0, cfg.axis_high};
   assign centre     = centre_sum[16:1];

   always_comb begin
      s1_in.z_kind   = head_job.z_kind;
      s1_in.stk_kind = head_job.stk_kind;
      s1_in.pz       = {1'b0, head_job.trig} * {15'b0, dmag};
      s1_in.px       = {16'b0, head_job.ux} * {16'b0, dmag};
      s1_in.py       = {16'b0, head_job.uy} * {16'b0, dmag};
   end

   always_comb begin
      s2_in.z_kind   = s1_ff.z_kind;
      s2_in.stk_kind = s1_ff.stk_kind;
      s2_in.xz       = s1_ff.pz;
      s2_in.xx       = s1_ff.px[31:1];
      s2_in.xy       = s1_ff.py[31:1];
      s2_in.px0      = s1_ff.px[0];
      s2_in.py0      = s1_ff.py[0];
      s2_in.qz       = div_est(s1_ff.pz);
      s2_in.qx       = div_est(s1_ff.px[31:1]);
      s2_in.qy       = div_est(s1_ff.py[31:1]);
   end

   always_comb begin
      fx_dx          = div_fix(s2_ff.xx, s2_ff.qx);
      fx_dy          = div_fix(s2_ff.xy, s2_ff.qy);
      s3_in.z_kind   = s2_ff.z_kind;
      s3_in.stk_kind = s2_ff.stk_kind;
      s3_in.dz       = div_fix(s2_ff.xz, s2_ff.qz);
      s3_in.dx.q     = fx_dx.q;
      s3_in.dx.rnz   = fx_dx.rnz || s2_ff.px0;
      s3_in.dy.q     = fx_dy.q;
      s3_in.dy.rnz   = fx_dy.rnz || s2_ff.py0;
   end

   always_comb begin
      out_in = '0;
      case (s3_ff.z_kind)
         gac_pkg::Z_SNAP: begin
            out_in[0]    = 1'b1;
            out_in[16:1] = cfg.axis_high;
         end
         gac_pkg::Z_SCALE: begin
            out_in[0]    = 1'b1;
            out_in[16:1] = offset(cfg.axis_low, s3_ff.dz, neg);
         end
         default: begin
            out_in[16:0] = '0;
         end
      endcase
      case (s3_ff.stk_kind)
         gac_pkg::STK_CENTRE: begin
            out_in[17]    = 1'b1;
            out_in[33:18] = centre;
            out_in[49:34] = centre;
         end
         gac_pkg::STK_SCALE: begin
            out_in[17]    = 1'b1;
            out_in[33:18] = offset(cfg.axis_low, s3_ff.dx, neg);
            out_in[49:34] = offset(cfg.axis_low, s3_ff.dy, neg);
         end
         default: begin
            out_in[49:17] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= !queue_empty;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b0, out_ff};

endmodule

@@ rtl/core/gamepad_axis_conditioner_core.sv @@
// Top level of the gamepad axis conditioner: configuration registers,
// front end, job queue and back end. Depends on gac_pkg, gac_front,
// gac_queue and gac_back.
//
// One poll beat in, one result beat out. The block takes a poll in every
// cycle while the job queue is not full; each accepted poll waits in the
// two-entry job queue while its products are formed, then passes the
// quotient estimate, quotient correction and offset stages of the back
// end on its way to the result register.
// req_tready falls only when the job queue is full because results are not
// being taken. Configuration writes are taken at any time but must only be
// made while no poll is in flight.
module gamepad_axis_conditioner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // trigger_left[14:0], assist_pressed[15], stick_x[31:16], stick_y[47:32],
   // elapsed_ms[55:48]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // z_valid[0], z_value[16:1], stick_valid[17], rx_value[33:18],
   // ry_value[49:34], zero padding[55:50]
   output logic [55:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   gac_pkg::cfg_type cfg_ff, cfg_in;
   gac_pkg::job_type push_job;
   gac_pkg::job_type head_job;
   logic             push;
   logic             pop;
   logic             queue_empty;
   logic             queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            gac_pkg::CSR_CLUTCH_ENABLE: cfg_in.clutch_enable        = csr_wdata[0];
            gac_pkg::CSR_BINDING_MODE:  cfg_in.binding_mode         = csr_wdata[0];
            gac_pkg::CSR_KNOB_OVERRIDE: cfg_in.knob_override_enable = csr_wdata[0];
            gac_pkg::CSR_INVERT_ASSIST: cfg_in.invert_assist        = csr_wdata[0];
            gac_pkg::CSR_AXIS_LOW:      cfg_in.axis_low             = csr_wdata;
            gac_pkg::CSR_AXIS_HIGH:     cfg_in.axis_high            = csr_wdata;
            gac_pkg::CSR_DEAD_BAND:     cfg_in.dead_band            = csr_wdata[14:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clutch_enable        <= 1'b0;
         cfg_ff.binding_mode         <= 1'b0;
         cfg_ff.knob_override_enable <= 1'b0;
         cfg_ff.invert_assist        <= 1'b0;
         cfg_ff.axis_low             <= 16'd1;
         cfg_ff.axis_high            <= 16'd32768;
         cfg_ff.dead_band            <= 15'd8000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   gac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   gac_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

@@ rtl/core/gac_checker.sv @@
// Port-level checks for the gamepad axis conditioner top level, and the
// bind that attaches them. Depends on gamepad_axis_conditioner_core.
module gac_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_z_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[16:1] == 16'd0)
      else $error("z value set without z valid");

   a_stick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[17] |-> rsp_tdata[49:18] == 32'd0)
      else $error("stick values set without stick valid");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result beat shown straight after reset");

endmodule

bind gamepad_axis_conditioner_core gac_checker u_gac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
